[rtl/core/lmtc_pkg.sv]
// ----------------------------------------------------------------------------
// LCD mode timing package
// Shared types, register indexes and reset values of the LCD mode timing core.
// ----------------------------------------------------------------------------
package lmtc_pkg;

    // Display modes as reported through STAT.
    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } lcd_mode_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_HBLANK_TICKS   = 3'd0;
    localparam logic [2:0] REG_OAM_TICKS      = 3'd1;
    localparam logic [2:0] REG_XFER_TAIL      = 3'd2;
    localparam logic [2:0] REG_VBLANK_LINE    = 3'd3;
    localparam logic [2:0] REG_TOTAL_LINES    = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 9;
    localparam int DOT_W       = 9;
    localparam int POS_W       = 8;

    // Reset values of the configuration registers.
    localparam logic [DOT_W-1:0] RST_HBLANK_TICKS = 9'd200;
    localparam logic [DOT_W-1:0] RST_OAM_TICKS    = 9'd80;
    localparam logic [DOT_W-1:0] RST_XFER_TAIL    = 9'd296;
    localparam logic [DOT_W-1:0] RST_VBLANK_LINE  = 9'd456;
    localparam logic [POS_W-1:0] RST_TOTAL_LINES  = 8'd154;

    // Default screen geometry.
    localparam int DEF_SCREEN_WIDTH  = 160;
    localparam int DEF_SCREEN_HEIGHT = 144;

    // Item widths on the stream ports.
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 32;

    typedef struct packed {
        logic [DOT_W-1:0] hblank_ticks;
        logic [DOT_W-1:0] oam_ticks;
        logic [DOT_W-1:0] xfer_tail_ticks;
        logic [DOT_W-1:0] vblank_line_ticks;
        logic [POS_W-1:0] total_lines;
    } cfg_t;

    typedef struct packed {
        lcd_mode_t        mode;
        logic [DOT_W-1:0] dot_count;
        logic [POS_W-1:0] line_count;
        logic [POS_W-1:0] column_count;
    } timing_state_t;

    // Result item, last field in the lowest bits.
    typedef struct packed {
        logic [POS_W-1:0] pixel_y;
        logic [POS_W-1:0] pixel_x;
        logic             pixel_valid;
        logic             vblank_irq;
        logic             mode_written;
        logic             line_written;
        logic [POS_W-1:0] line_out;
        lcd_mode_t        lcd_mode_out;
    } result_t;

endpackage

[rtl/core/lmtc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// LCD mode timing configuration registers
// Holds the five timing registers written through the plain write port.
// ----------------------------------------------------------------------------
module lmtc_cfg_regs
    import lmtc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    // Decode the index; indexes past the last register are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hblank_ticks      <= RST_HBLANK_TICKS;
            cfg_reg.oam_ticks         <= RST_OAM_TICKS;
            cfg_reg.xfer_tail_ticks   <= RST_XFER_TAIL;
            cfg_reg.vblank_line_ticks <= RST_VBLANK_LINE;
            cfg_reg.total_lines       <= RST_TOTAL_LINES;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_HBLANK_TICKS: cfg_reg.hblank_ticks      <= cfg_data;
                REG_OAM_TICKS:    cfg_reg.oam_ticks         <= cfg_data;
                REG_XFER_TAIL:    cfg_reg.xfer_tail_ticks   <= cfg_data;
                REG_VBLANK_LINE:  cfg_reg.vblank_line_ticks <= cfg_data;
                REG_TOTAL_LINES:  cfg_reg.total_lines       <= cfg_data[POS_W-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/lmtc_step.sv]
// ----------------------------------------------------------------------------
// LCD mode timing step logic
// Next state and result item for one dot tick, purely combinational.
// ----------------------------------------------------------------------------
module lmtc_step
    import lmtc_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
)
(
    input  cfg_t          cfg,
    input  timing_state_t cur,
    input  logic          dot_valid,
    output timing_state_t nxt,
    output result_t       res
);

    localparam logic [POS_W-1:0] WIDTH_C  = POS_W'(SCREEN_WIDTH);
    localparam logic [POS_W-1:0] HEIGHT_C = POS_W'(SCREEN_HEIGHT);

    logic [DOT_W:0]   dot_inc;
    logic [DOT_W-1:0] dot_wrap;
    logic [POS_W-1:0] line_inc;
    logic [POS_W-1:0] vb_line;

    // Incremented counts; the exceeds compares use the one bit wider count.
    assign dot_inc  = {1'b0, cur.dot_count} + (DOT_W+1)'(1);
    assign dot_wrap = dot_inc[DOT_W-1:0];
    assign line_inc = cur.line_count + POS_W'(1);
    assign vb_line  = (dot_wrap == cfg.vblank_line_ticks) ? line_inc : cur.line_count;

    always_comb
    begin
        nxt = cur;
        res = '0;
        if (dot_valid)
        begin
            unique case (cur.mode)
                MODE_HBLANK:
                begin
                    if (dot_inc > {1'b0, cfg.hblank_ticks})
                    begin
                        nxt.dot_count    = '0;
                        nxt.line_count   = line_inc;
                        res.line_written = 1'b1;
                        res.mode_written = 1'b1;
                        if (line_inc == HEIGHT_C)
                        begin
                            res.vblank_irq = 1'b1;
                            nxt.mode       = MODE_VBLANK;
                        end
                        else
                        begin
                            nxt.mode = MODE_OAM;
                        end
                    end
                    else
                    begin
                        nxt.dot_count = dot_wrap;
                    end
                end
                MODE_VBLANK:
                begin
                    // A line ends when the wrapped count hits the line length.
                    if (dot_wrap == cfg.vblank_line_ticks)
                    begin
                        nxt.dot_count    = '0;
                        nxt.line_count   = line_inc;
                        res.line_written = 1'b1;
                    end
                    else
                    begin
                        nxt.dot_count = dot_wrap;
                    end
                    // Frame restart is checked on every vblank tick.
                    if (vb_line == cfg.total_lines)
                    begin
                        nxt.mode         = MODE_OAM;
                        nxt.column_count = '0;
                        nxt.line_count   = '0;
                        res.mode_written = 1'b1;
                        res.line_written = 1'b1;
                    end
                end
                MODE_OAM:
                begin
                    if (dot_inc > {1'b0, cfg.oam_ticks})
                    begin
                        nxt.dot_count    = '0;
                        nxt.mode         = MODE_XFER;
                        res.mode_written = 1'b1;
                    end
                    else
                    begin
                        nxt.dot_count = dot_wrap;
                    end
                end
                MODE_XFER:
                begin
                    // One pixel per dot until the column reaches the width.
                    if (cur.column_count < WIDTH_C)
                    begin
                        res.pixel_valid  = 1'b1;
                        res.pixel_x      = cur.column_count;
                        res.pixel_y      = cur.line_count;
                        nxt.column_count = cur.column_count + POS_W'(1);
                    end
                    else if (dot_inc > {1'b0, cfg.xfer_tail_ticks})
                    begin
                        nxt.dot_count    = '0;
                        nxt.mode         = MODE_HBLANK;
                        nxt.column_count = '0;
                        res.mode_written = 1'b1;
                    end
                    else
                    begin
                        nxt.dot_count = dot_wrap;
                    end
                end
                default:
                begin
                    nxt = cur;
                end
            endcase
        end
        res.lcd_mode_out = nxt.mode;
        res.line_out     = nxt.line_count;
    end

endmodule

[rtl/core/lcd_mode_timing_controller_core.sv]
// ----------------------------------------------------------------------------
// LCD mode timing controller core
// Dot-driven LCD mode sequencer with LY, STAT mode, vblank and pixel requests.
// ----------------------------------------------------------------------------
// Each item accepted on the slave side is one dot tick (tdata bit 0 set) or an
// idle tick (bit 0 clear), and each produces exactly one result item on the next
// clock. The core takes one item per clock for as long as the master side
// takes results; the single output register sets that figure, and a stalled
// master side holds the slave side off through tready. Configuration writes
// take effect on the next clock and are meant to be made while no item is in
// flight.
// ----------------------------------------------------------------------------
module lcd_mode_timing_controller_core
    import lmtc_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write port.
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // Tick input.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,   // [0] dot_valid, [7:1] zero
    // Result output.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [1:0] lcd_mode_out, [9:2] line_out, [10] line_written, [11] mode_written,
    // [12] vblank_irq, [13] pixel_valid, [21:14] pixel_x, [29:22] pixel_y,
    // [31:30] zero
    output logic [OUT_DATA_W-1:0]  m_tdata
);

    cfg_t          cfg;
    timing_state_t state_reg;
    timing_state_t state_next;
    result_t       res;
    logic          accept;
    logic          m_tvalid_reg;
    result_t       m_data_reg;

    lmtc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lmtc_step #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_step (
        .cfg       (cfg),
        .cur       (state_reg),
        .dot_valid (s_tdata[0]),
        .nxt       (state_next),
        .res       (res)
    );

    // The output register frees up whenever it is empty or being drained.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Timing state advances once per accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode         <= MODE_OAM;
            state_reg.dot_count    <= '0;
            state_reg.line_count   <= '0;
            state_reg.column_count <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // Result register on the master side.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (accept)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(OUT_DATA_W - $bits(result_t))'(0), m_data_reg};

    // A vblank interrupt always comes with an LY write and the vblank mode.
    a_irq_vblank : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_data_reg.vblank_irq) |->
            (m_data_reg.lcd_mode_out == MODE_VBLANK && m_data_reg.line_written))
        else $error("vblank interrupt without vblank entry");

    // Pixel requests are only made during transfer and inside the screen width.
    a_pixel_xfer : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_data_reg.pixel_valid) |->
            (m_data_reg.lcd_mode_out == MODE_XFER
             && m_data_reg.pixel_x < POS_W'(SCREEN_WIDTH)))
        else $error("pixel request outside transfer or past the width");

    // The column counter never runs past the screen width.
    a_column_bound : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.column_count <= POS_W'(SCREEN_WIDTH))
        else $error("column counter past the screen width");

    // An accepted item while the result is stalled would lose a result.
    a_no_overrun : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> ($stable(m_data_reg) && m_tvalid))
        else $error("stalled result overwritten");

endmodule
